// ===== rtl/slr_pkg.sv =====
// Shared types and constants of the sample loop recorder.
package slr_pkg;

  localparam int unsigned DefBufferDepth = 448;

  localparam int unsigned SampleW = 8;
  localparam int unsigned SpeedW  = 10;
  localparam int unsigned PeriodW = 17;

  localparam int unsigned MinLoopLen   = 6;
  localparam int unsigned WarnMargin   = 64;
  localparam int unsigned PeriodBase   = 1040;
  localparam int unsigned PeriodShift  = 6;
  localparam int unsigned PeriodOffset = 600;
  localparam int unsigned PeriodReset  = 67160;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [SpeedW-1:0]  speed_t;
  typedef logic [PeriodW-1:0] period_t;

  typedef struct packed {
    logic    use_mem;
    sample_t duty;
    logic    led;
    period_t period;
  } tick_res_t;

endpackage

// ===== rtl/slr_in_if.sv =====
// Request channel carrying one tick: sample, button level and speed setting.
interface slr_in_if;
  import slr_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    button_held;
  speed_t  speed_setting;

  modport source (output valid, sample, button_held, speed_setting, input ready);
  modport sink (input valid, sample, button_held, speed_setting, output ready);
endinterface

// ===== rtl/slr_out_if.sv =====
// Result channel carrying the duty, LED level and tick period of one tick.
interface slr_out_if;
  import slr_pkg::*;

  logic    valid;
  logic    ready;
  sample_t duty;
  logic    led_on;
  period_t period_us;

  modport source (output valid, duty, led_on, period_us, input ready);
  modport sink (input valid, duty, led_on, period_us, output ready);
endinterface

// ===== rtl/sample_loop_recorder.sv =====
// Top level of the sample loop recorder.
//
// One request on in_i is one tick: the live sample, the record button level
// and the speed setting. Every request gives exactly one result on out_o:
// the PWM duty, the LED level and the period to wait before the next tick.
// Both channels move a request when valid and ready are high at a clock edge.
// A result leaves at the earliest after the registered read of the sample
// buffer and the output register. Requests are taken back to back, one per
// cycle, while out_o takes its results; the control state updates in the
// cycle of acceptance, so writes and reads of the buffer from consecutive
// ticks never conflict. While out_o is stalled the block holds one result
// and one more in flight, then drops in_i.ready.
// Reset clears the index, length and loop state, sets the LED on and the
// period to its slowest value; the sample buffer is not cleared and needs
// no start-up pass, since playback only reads entries that were recorded.
module sample_loop_recorder #(
  parameter int unsigned BufferDepth = slr_pkg::DefBufferDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  slr_in_if.sink    in_i,
  slr_out_if.source out_o
);
  import slr_pkg::*;

  localparam int unsigned IdxW = $clog2(BufferDepth);

  logic            tick;
  logic            mem_we;
  logic            mem_re;
  logic [IdxW-1:0] mem_addr;
  sample_t         rdata;
  tick_res_t       res;

  assign tick = in_i.valid && in_i.ready;

  slr_core #(
    .BufferDepth (BufferDepth),
    .IdxW        (IdxW)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick),
    .sample_i   (in_i.sample),
    .button_i   (in_i.button_held),
    .speed_i    (in_i.speed_setting),
    .mem_we_o   (mem_we),
    .mem_re_o   (mem_re),
    .mem_addr_o (mem_addr),
    .res_o      (res)
  );

  slr_mem #(
    .Depth (BufferDepth),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (in_i.sample),
    .rdata_o (rdata)
  );

  slr_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (tick),
    .res_i       (res),
    .rdata_i     (rdata),
    .ready_o     (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .duty_o      (out_o.duty),
    .led_o       (out_o.led_on),
    .period_o    (out_o.period_us)
  );
endmodule

// ===== rtl/slr_mem.sv =====
// Sample buffer: one port with a shared address for writes and registered reads.
module slr_mem #(
  parameter int unsigned Depth = slr_pkg::DefBufferDepth,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  slr_pkg::sample_t wdata_i,
  output slr_pkg::sample_t rdata_o
);
  import slr_pkg::*;

  sample_t mem_q [Depth];
  sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/slr_core.sv =====
// Loop control state: index, length, LED and period update for each tick.
module slr_core #(
  parameter int unsigned BufferDepth = slr_pkg::DefBufferDepth,
  parameter int unsigned IdxW        = $clog2(BufferDepth)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                tick_i,
  input  slr_pkg::sample_t    sample_i,
  input  logic                button_i,
  input  slr_pkg::speed_t     speed_i,
  output logic                mem_we_o,
  output logic                mem_re_o,
  output logic [IdxW-1:0]     mem_addr_o,
  output slr_pkg::tick_res_t  res_o
);
  import slr_pkg::*;

  localparam int unsigned LenW    = $clog2(BufferDepth + 1);
  localparam int unsigned BeatLen = BufferDepth >> 4;
  localparam int unsigned BeatW   = $clog2(BeatLen);

  logic [IdxW-1:0]  play_idx_q, play_idx_d;
  logic [LenW-1:0]  loop_len_q, loop_len_d;
  logic             loop_fixed_q, loop_fixed_d;
  logic             prev_btn_q, prev_btn_d;
  logic             full_hold_q, full_hold_d;
  logic             led_q, led_d;
  period_t          period_q, period_d;
  logic [BeatW-1:0] beat_pos_q, beat_pos_d;
  logic [1:0]       beat_num_q, beat_num_d;

  logic             hold;
  logic             take_start;
  logic [IdxW-1:0]  pos;
  logic [LenW-1:0]  len0;
  logic [LenW-1:0]  len_inc;
  logic [LenW-1:0]  nxt;
  logic [BeatW-1:0] bpos;
  logic [1:0]       bnum;
  logic             wrap;
  logic             play;
  logic             led_w;

  always_comb begin
    hold       = full_hold_q && button_i;
    take_start = button_i && !prev_btn_q && !loop_fixed_q;
    pos        = take_start ? '0 : play_idx_q;
    len0       = take_start ? '0 : loop_len_q;
    bpos       = take_start ? '0 : beat_pos_q;
    bnum       = take_start ? '0 : beat_num_q;
    len_inc    = len0 + 1'b1;

    play_idx_d   = play_idx_q;
    loop_len_d   = loop_len_q;
    loop_fixed_d = loop_fixed_q;
    prev_btn_d   = prev_btn_q;
    full_hold_d  = 1'b0;
    period_d     = period_q;
    beat_pos_d   = beat_pos_q;
    beat_num_d   = beat_num_q;
    led_w        = led_q;
    nxt          = LenW'(pos) + 1'b1;
    wrap         = 1'b0;

    if (hold) begin
      led_w       = !led_q;
      full_hold_d = 1'b1;
    end else begin
      loop_len_d = len0;
      if (button_i) begin
        if (!loop_fixed_q && (len0 < LenW'(BufferDepth))) begin
          loop_len_d = len_inc;
          if ((len_inc > LenW'(BufferDepth - WarnMargin)) && (pos[1:0] == 2'b00)) begin
            led_w = !led_w;
          end
          if (len_inc == LenW'(BufferDepth)) begin
            led_w       = 1'b0;
            full_hold_d = 1'b1;
          end
        end
      end else if (prev_btn_q && !loop_fixed_q && (loop_len_q >= LenW'(MinLoopLen))) begin
        loop_fixed_d = 1'b1;
      end

      if (bpos == '0) begin
        led_w = 1'b0;
      end
      if (loop_fixed_d) begin
        if ((LenW'(pos) > LenW'(BufferDepth - BeatLen)) && (bpos[2:0] == 3'b000)) begin
          led_w = !led_w;
        end else if (bnum == 2'b11) begin
          if (bpos == BeatW'(BeatLen >> 1)) begin
            led_w = 1'b1;
          end
        end else if (bpos == BeatW'(BeatLen >> 2)) begin
          led_w = 1'b1;
        end
      end else if (bpos >= BeatW'(BeatLen >> 2)) begin
        led_w = 1'b1;
      end

      wrap = loop_fixed_d ? (nxt >= loop_len_d) : (nxt >= LenW'(BufferDepth));
      if (wrap) begin
        play_idx_d = '0;
        beat_pos_d = '0;
        beat_num_d = '0;
      end else begin
        play_idx_d = nxt[IdxW-1:0];
        if (bpos == BeatW'(BeatLen - 1)) begin
          beat_pos_d = '0;
          beat_num_d = bnum + 2'b01;
        end else begin
          beat_pos_d = bpos + 1'b1;
          beat_num_d = bnum;
        end
      end

      if (!button_i) begin
        period_d = ((PeriodW'(PeriodBase) - PeriodW'(speed_i)) << PeriodShift)
                   + PeriodW'(PeriodOffset);
      end
      prev_btn_d = button_i;
    end
    led_d = led_w;
  end

  always_comb begin
    play       = !hold && loop_fixed_d && !button_i;
    mem_we_o   = tick_i && !hold && button_i;
    mem_re_o   = tick_i && play;
    mem_addr_o = pos;

    res_o.use_mem = play && (LenW'(pos) < loop_len_d);
    res_o.duty    = play ? '0 : sample_i;
    res_o.led     = led_d;
    res_o.period  = period_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      play_idx_q   <= '0;
      loop_len_q   <= '0;
      loop_fixed_q <= 1'b0;
      prev_btn_q   <= 1'b1;
      full_hold_q  <= 1'b0;
      led_q        <= 1'b1;
      period_q     <= PeriodW'(PeriodReset);
      beat_pos_q   <= '0;
      beat_num_q   <= '0;
    end else if (tick_i) begin
      play_idx_q   <= play_idx_d;
      loop_len_q   <= loop_len_d;
      loop_fixed_q <= loop_fixed_d;
      prev_btn_q   <= prev_btn_d;
      full_hold_q  <= full_hold_d;
      led_q        <= led_d;
      period_q     <= period_d;
      beat_pos_q   <= beat_pos_d;
      beat_num_q   <= beat_num_d;
    end
  end

`ifndef ASSERT_OFF
  a_fixed_idx_in_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loop_fixed_q |-> (LenW'(play_idx_q) < loop_len_q))
    else $error("play index outside the fixed loop");
  a_fixed_min_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loop_fixed_q |-> (loop_len_q >= LenW'(MinLoopLen)))
    else $error("fixed loop shorter than the minimum");
  a_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_hold_q |-> ((loop_len_q == LenW'(BufferDepth)) && !loop_fixed_q))
    else $error("full hold without a full buffer");
  a_beat_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(beat_pos_q) < BeatLen)
    else $error("beat position out of range");
  a_no_write_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_i && full_hold_q && button_i) |-> !mem_we_o)
    else $error("sample stored while the buffer is full");
`endif
endmodule

// ===== rtl/slr_out.sv =====
// Two-stage result pipeline: read-data alignment stage and output register.
module slr_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  slr_pkg::tick_res_t res_i,
  input  slr_pkg::sample_t   rdata_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output slr_pkg::sample_t   duty_o,
  output logic               led_o,
  output slr_pkg::period_t   period_o
);
  import slr_pkg::*;

  logic      p_valid_q, p_valid_d;
  tick_res_t p_res_q;
  logic      o_valid_q, o_valid_d;
  sample_t   o_duty_q;
  logic      o_led_q;
  period_t   o_period_q;
  logic      adv;

  always_comb begin
    adv       = !o_valid_q || out_ready_i;
    ready_o   = !p_valid_q || adv;
    p_valid_d = push_i ? 1'b1 : (adv ? 1'b0 : p_valid_q);
    o_valid_d = adv ? p_valid_q : o_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      p_res_q <= res_i;
    end
    if (adv && p_valid_q) begin
      o_duty_q   <= p_res_q.use_mem ? rdata_i : p_res_q.duty;
      o_led_q    <= p_res_q.led;
      o_period_q <= p_res_q.period;
    end
  end

  assign out_valid_o = o_valid_q;
  assign duty_o      = o_duty_q;
  assign led_o       = o_led_q;
  assign period_o    = o_period_q;
endmodule
